[sv/bsr_pkg.sv]
package bsr_pkg;

    localparam int TimeW  = 20;
    localparam int GainW  = 22;
    localparam int ShapeW = 16;
    localparam int QuotW  = 24;
    localparam int MantW  = 31;
    localparam int FracW  = 16;
    localparam int PosW   = 5;
    localparam int LogW   = 22;
    localparam int ProdW  = 39;
    localparam int ShiftW = 13;
    localparam int MagW   = 53;
    localparam int LogSteps = 16;
    localparam int ExpSteps = 16;

    typedef enum logic [2:0] {
        CFG_START = 3'd0,
        CFG_END   = 3'd1,
        CFG_GAIN  = 3'd2,
        CFG_ALPHA = 3'd3,
        CFG_BETA  = 3'd4
    } cfg_idx_t;

    // control carried beside each word through every stage
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             live;
        logic             neg;
        logic [GainW-1:0] kmag;
    } tag_t;

    typedef struct packed {
        tag_t             tag;
        logic [TimeW-1:0] rem;
        logic [TimeW-1:0] div;
        logic [QuotW-1:0] quot;
    } div_t;

    typedef struct packed {
        tag_t             tag;
        logic [MantW-1:0] m_x;
        logic [MantW-1:0] m_y;
        logic [FracW-1:0] f_x;
        logic [FracW-1:0] f_y;
        logic [PosW-1:0]  p_x;
        logic [PosW-1:0]  p_y;
    } log_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [ProdW-1:0]  pa;
        logic signed [ProdW-1:0]  pb;
    } prod_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [ShiftW-1:0] s;
        logic [FracW-1:0]         f;
        logic [MantW-1:0]         acc;
    } exp_t;

    typedef struct packed {
        tag_t                     tag;
        logic signed [ShiftW-1:0] s;
        logic [MagW-1:0]          mag;
    } mul_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] rem;
        logic [63:0] bit_v;
        res   = 64'd0;
        rem   = n;
        bit_v = 64'd1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end
            else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // 2^(2^-idx) in Q1.30 by repeated integer square roots
    function automatic logic [MantW-1:0] root_q30(input int idx);
        logic [63:0] r;
        r = 64'd1 << 31;
        for (int i = 1; i <= idx; i++) begin
            r = isqrt64(r << 30);
        end
        return r[MantW-1:0];
    endfunction

endpackage

[sv/bsr_div_cell.sv]
module bsr_div_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bsr_pkg::div_t d_in,
    output bsr_pkg::div_t d_out
);
    import bsr_pkg::*;

    div_t             data_reg;
    div_t             data_next;
    logic [TimeW:0]   rem2;
    logic             ge;

    // one quotient bit per cell
    always_comb
    begin
        rem2      = {d_in.rem, 1'b0};
        ge        = rem2 >= {1'b0, d_in.div};
        data_next = d_in;
        data_next.rem  = ge ? TimeW'(rem2 - {1'b0, d_in.div}) : rem2[TimeW-1:0];
        data_next.quot = {d_in.quot[QuotW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (en)
            data_reg <= data_next;
    end

    assign d_out = data_reg;
endmodule

[sv/bsr_log_cell.sv]
module bsr_log_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bsr_pkg::log_t l_in,
    output bsr_pkg::log_t l_out
);
    import bsr_pkg::*;

    log_t                 data_reg;
    log_t                 data_next;
    logic [2*MantW-1:0]   sq_x;
    logic [2*MantW-1:0]   sq_y;
    logic [MantW:0]       t_x;
    logic [MantW:0]       t_y;

    // square the mantissa, emit one fraction bit, renormalize
    always_comb
    begin
        sq_x = l_in.m_x * l_in.m_x;
        sq_y = l_in.m_y * l_in.m_y;
        t_x  = sq_x[2*MantW-1:30];
        t_y  = sq_y[2*MantW-1:30];
        data_next     = l_in;
        data_next.m_x = t_x[MantW] ? t_x[MantW:1] : t_x[MantW-1:0];
        data_next.m_y = t_y[MantW] ? t_y[MantW:1] : t_y[MantW-1:0];
        data_next.f_x = {l_in.f_x[FracW-2:0], t_x[MantW]};
        data_next.f_y = {l_in.f_y[FracW-2:0], t_y[MantW]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (en)
            data_reg <= data_next;
    end

    assign l_out = data_reg;
endmodule

[sv/bsr_exp_cell.sv]
module bsr_exp_cell #(
    parameter int Step = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  bsr_pkg::exp_t e_in,
    output bsr_pkg::exp_t e_out
);
    import bsr_pkg::*;

    localparam logic [MantW-1:0] Root = root_q30(Step);

    exp_t                 data_reg;
    exp_t                 data_next;
    logic [2*MantW-1:0]   prod;

    // multiply in this cell's root when the leading fraction bit is set
    always_comb
    begin
        prod      = e_in.acc * Root;
        data_next = e_in;
        data_next.f = {e_in.f[FracW-2:0], 1'b0};
        if (e_in.f[FracW-1])
            data_next.acc = prod[MantW+29:30];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            data_reg <= '0;
        else if (en)
            data_reg <= data_next;
    end

    assign e_out = data_reg;
endmodule

[sv/beta_shape_response_eval.sv]
// channel   dir  handshake          tdata / tuser / tlast
// s_axis    in   s_tvalid/s_tready  tdata[19:0] sample_time; tlast last_in
// m_axis    out  m_tvalid/m_tready  tdata[31:0] model_value; tuser saturated; tlast last_out
// cfg       in   cfg_we             cfg_index register, cfg_data value
//
// One word per cycle sustained while m_tready does not stall; stages: front, 24 divider cells,
// normalize, 16 log2 squaring cells, exponent products, sum, 16 exp2 root
// cells, gain multiply, shift/clip output register.
// Reset clears all stage valids and loads the default register values.
// A stall on m_tready holds the whole chain; s_tready follows it.
module beta_shape_response_eval (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [19:0] sample_time, [23:20] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] model_value
    output logic        m_tuser,   // [0] saturated
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [21:0] cfg_data
);
    import bsr_pkg::*;

    logic [TimeW-1:0]  start_reg;
    logic [TimeW-1:0]  end_reg;
    logic [GainW-1:0]  gain_reg;
    logic [ShapeW-1:0] alpha_reg;
    logic [ShapeW-1:0] beta_reg;

    logic adv;

    div_t  front_next;
    div_t  div_c [0:QuotW];
    log_t  norm_next;
    log_t  norm_reg;
    log_t  log_c [0:LogSteps];
    prod_t prod_next;
    prod_t prod_reg;
    exp_t  sum_next;
    exp_t  exp_c [0:ExpSteps];
    mul_t  mul_next;
    mul_t  mul_reg;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;
    logic        out_sat_reg;
    logic        out_sat_next;
    logic        out_last_reg;
    logic        out_last_next;

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= TimeW'(432);
            end_reg   <= TimeW'(1248);
            gain_reg  <= GainW'(256);
            alpha_reg <= ShapeW'(8192);
            beta_reg  <= ShapeW'(8192);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START: start_reg <= cfg_data[TimeW-1:0];
                CFG_END:   end_reg   <= cfg_data[TimeW-1:0];
                CFG_GAIN:  gain_reg  <= cfg_data;
                CFG_ALPHA: alpha_reg <= cfg_data[ShapeW-1:0];
                CFG_BETA:  beta_reg  <= cfg_data[ShapeW-1:0];
                default: ;
            endcase
        end
    end

    // front: window test and divider seed
    always_comb
    begin
        logic [TimeW-1:0] t;
        t = s_tdata[TimeW-1:0];
        front_next           = '0;
        front_next.tag.valid = s_tvalid;
        front_next.tag.last  = s_tlast;
        front_next.tag.neg   = gain_reg[GainW-1];
        front_next.tag.kmag  = gain_reg[GainW-1] ? GainW'(-gain_reg) : gain_reg;
        front_next.tag.live  = (t > start_reg) && (t < end_reg) && (gain_reg != '0);
        front_next.rem       = TimeW'(t - start_reg);
        front_next.div       = TimeW'(end_reg - start_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_c[0] <= '0;
        else if (adv)
            div_c[0] <= front_next;
    end

    for (genvar i = 0; i < QuotW; i++)
    begin : g_div
        bsr_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .d_in  (div_c[i]),
            .d_out (div_c[i+1])
        );
    end

    // normalize x and 1-x into Q1.30
    always_comb
    begin
        logic [QuotW-1:0] x;
        logic [QuotW-1:0] y;
        logic [PosW-1:0]  px;
        logic [PosW-1:0]  py;
        x  = div_c[QuotW].quot;
        y  = QuotW'(25'h100_0000 - {1'b0, x});
        px = '0;
        py = '0;
        for (int b = 0; b < QuotW; b++)
        begin
            if (x[b])
                px = PosW'(b);
            if (y[b])
                py = PosW'(b);
        end
        norm_next     = '0;
        norm_next.tag = div_c[QuotW].tag;
        norm_next.p_x = px;
        norm_next.p_y = py;
        norm_next.m_x = MantW'({7'd0, x} << (PosW'(30) - px));
        norm_next.m_y = MantW'({7'd0, y} << (PosW'(30) - py));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            norm_reg <= '0;
        else if (adv)
            norm_reg <= norm_next;
    end

    assign log_c[0] = norm_reg;

    for (genvar i = 0; i < LogSteps; i++)
    begin : g_log
        bsr_log_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .l_in  (log_c[i]),
            .l_out (log_c[i+1])
        );
    end

    // exponent times log2, Q12 * Q16
    always_comb
    begin
        logic [5:0]              ix;
        logic [5:0]              iy;
        logic signed [LogW-1:0]  lx;
        logic signed [LogW-1:0]  ly;
        logic signed [ShapeW:0]  ea;
        logic signed [ShapeW:0]  eb;
        ix = {1'b0, log_c[LogSteps].p_x} - 6'd24;
        iy = {1'b0, log_c[LogSteps].p_y} - 6'd24;
        lx = signed'({ix, log_c[LogSteps].f_x});
        ly = signed'({iy, log_c[LogSteps].f_y});
        ea = signed'({1'b0, alpha_reg}) - 17'sd4096;
        eb = signed'({1'b0, beta_reg}) - 17'sd4096;
        prod_next.tag = log_c[LogSteps].tag;
        prod_next.pa  = ea * lx;
        prod_next.pb  = eb * ly;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_reg <= '0;
        else if (adv)
            prod_reg <= prod_next;
    end

    // split the sum into integer shift and Q0.16 fraction
    always_comb
    begin
        logic signed [ProdW:0] lsum;
        lsum = {prod_reg.pa[ProdW-1], prod_reg.pa} + {prod_reg.pb[ProdW-1], prod_reg.pb};
        sum_next.tag = prod_reg.tag;
        sum_next.s   = signed'({lsum[ProdW], lsum[ProdW:28]}) - 13'sd30;
        sum_next.f   = lsum[27:12];
        sum_next.acc = MantW'(1) << 30;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_c[0] <= '0;
        else if (adv)
            exp_c[0] <= sum_next;
    end

    for (genvar i = 0; i < ExpSteps; i++)
    begin : g_exp
        bsr_exp_cell #(.Step(i + 1)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (adv),
            .e_in  (exp_c[i]),
            .e_out (exp_c[i+1])
        );
    end

    always_comb
    begin
        mul_next.tag = exp_c[ExpSteps].tag;
        mul_next.s   = exp_c[ExpSteps].s;
        mul_next.mag = exp_c[ExpSteps].tag.kmag * exp_c[ExpSteps].acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_reg <= '0;
        else if (adv)
            mul_reg <= mul_next;
    end

    // shift by the integer part and clip
    always_comb
    begin
        logic [MagW-1:0]          lim;
        logic [MagW-1:0]          wide;
        logic [31:0]              val;
        logic signed [ShiftW-1:0] nsh;
        logic                     sat;
        lim  = mul_reg.tag.neg ? MagW'(33'h0_8000_0000) : MagW'(33'h0_7fff_ffff);
        nsh  = -mul_reg.s;
        wide = '0;
        val  = '0;
        sat  = 1'b0;
        if (!mul_reg.s[ShiftW-1])
        begin
            if (mul_reg.s >= 13'sd31)
                sat = 1'b1;
            else if (mul_reg.mag > (lim >> mul_reg.s[4:0]))
                sat = 1'b1;
            else
            begin
                wide = mul_reg.mag << mul_reg.s[4:0];
                val  = wide[31:0];
            end
        end
        else if (nsh < 13'sd64)
        begin
            wide = mul_reg.mag >> nsh[5:0];
            if (wide > lim)
                sat = 1'b1;
            else
                val = wide[31:0];
        end
        if (sat)
            val = lim[31:0];
        if (!mul_reg.tag.live)
        begin
            val = '0;
            sat = 1'b0;
        end
        out_data_next  = mul_reg.tag.neg ? 32'(-val) : val;
        out_sat_next   = sat;
        out_last_next  = mul_reg.tag.last;
        out_valid_next = mul_reg.tag.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_sat_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            out_sat_reg   <= out_sat_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;
endmodule

[sv/bsr_checker.sv]
module bsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
        else $error("saturated word not at a limit");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid || $past(s_tvalid, 1) || rst_n)
        else $error("result word without input");
endmodule

bind beta_shape_response_eval bsr_checker u_bsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
